// File: rtl/ordered_array_list_defines.svh
// Assertion macros for the ordered array list.
// Included by the modules that carry assertions; no other dependencies.
`ifndef ORDERED_ARRAY_LIST_DEFINES_SVH
`define ORDERED_ARRAY_LIST_DEFINES_SVH
`ifndef SYNTHESIS
`define OAL_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define OAL_ASSERT(label, prop, msg) \
  `OAL_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)
`else
`define OAL_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define OAL_ASSERT(label, prop, msg)
`endif
`endif

// File: rtl/oal_pkg.sv
// Shared types, codes and default sizes for the ordered array list.
// No dependencies.
`timescale 1ns / 1ps
package oal_pkg;

  localparam int unsigned CAPACITY_DEF    = 16;
  localparam int unsigned ENTRY_WIDTH_DEF = 32;

  localparam int unsigned REQ_W   = 3;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned ST_W    = 2;
  localparam int unsigned FPOS_W  = 4;
  localparam int unsigned COUNT_W = 5;

  localparam logic [REQ_W-1:0] REQ_INSERT     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND     = 3'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE_AT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_READ       = 3'd3;
  localparam logic [REQ_W-1:0] REQ_FIND       = 3'd4;
  localparam logic [REQ_W-1:0] REQ_REMOVE_VAL = 3'd5;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE   = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
  localparam logic [ST_W-1:0] ST_MISSING = 2'd3;

  typedef struct packed {
    logic shift_up;
    logic shift_down;
  } oal_cmd_t;

endpackage

// File: rtl/ordered_array_list.sv
// Ordered array list top level: request sequencer, row of entry cells,
// first-hit picker and result register. Depends on oal_pkg, oal_cell,
// oal_prio and ordered_array_list_defines.svh.
//
//   channel | direction | handshake              | fields
//   in      | into      | in_valid_i/in_ready_o  | req_type, position, item_value
//   out     | out of    | out_valid_o/out_ready_i| status, found_position,
//           |           |                        | read_data, entry_count
//
// One item at a time, none taken until done: accept, compare in all cells
// (match vector registered), then pick first hit and shift the cell row.
// The shift step waits while the previous result has not been taken.
// Reset clears the count and control state; cell contents stay undefined.
`timescale 1ns / 1ps
`include "ordered_array_list_defines.svh"
module ordered_array_list import oal_pkg::*; #(
  parameter int unsigned CAPACITY    = CAPACITY_DEF,
  parameter int unsigned ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [REQ_W-1:0]   req_type_i,
  input  logic [POS_W-1:0]   position_i,
  input  logic [VAL_W-1:0]   item_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ST_W-1:0]    status_o,
  output logic [FPOS_W-1:0]  found_position_o,
  output logic [VAL_W-1:0]   read_data_o,
  output logic [COUNT_W-1:0] entry_count_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SRCH  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0] state_q, state_d;

  logic [REQ_W-1:0] req_q;
  logic [POS_W-1:0] pos_q;
  logic [VAL_W-1:0] val_q;
  logic [CNT_W-1:0] count_q, count_d;

  logic [CAPACITY-1:0] hit_raw, hit_q;

  logic out_valid_q;
  logic [ST_W-1:0]    status_q, status_d;
  logic [FPOS_W-1:0]  fpos_q;
  logic [VAL_W-1:0]   rdata_q;
  logic [COUNT_W-1:0] cnt_out_q;

  logic                   accept;
  logic                   out_free;
  logic                   apply_go;
  logic [ENTRY_WIDTH-1:0] key;
  logic [ENTRY_WIDTH-1:0] cell_data [CAPACITY];
  logic [CMP_W-1:0]       pos_ext, cnt_ext;
  logic [IDX_W-1:0]       pos_idx;
  logic                   found;
  logic [IDX_W-1:0]       found_idx;
  oal_cmd_t               cmd;
  logic [IDX_W-1:0]       tidx;
  logic [IDX_W-1:0]       fpos_d;
  logic [ENTRY_WIDTH-1:0] rdata_d;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign apply_go = (state_q == S_APPLY) && out_free;

  assign key     = ENTRY_WIDTH'(val_q);
  assign pos_ext = CMP_W'(pos_q);
  assign cnt_ext = CMP_W'(count_q);
  assign pos_idx = pos_ext[IDX_W-1:0];

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [ENTRY_WIDTH-1:0] prev_w, next_w;
    if (k == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid_lo
      assign prev_w = cell_data[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_mid_hi
      assign next_w = cell_data[k+1];
    end

    logic cell_hit;
    oal_cell #(
      .ENTRY_WIDTH (ENTRY_WIDTH),
      .IDX_W       (IDX_W),
      .CELL_IDX    (k)
    ) u_cell (
      .clk_i   (clk_i),
      .en_i    (apply_go),
      .cmd_i   (cmd),
      .idx_i   (tidx),
      .value_i (key),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .data_o  (cell_data[k]),
      .hit_o   (cell_hit)
    );
    assign hit_raw[k] = cell_hit && (CNT_W'(k) < count_q);
  end

  oal_prio #(
    .N     (CAPACITY),
    .IDX_W (IDX_W)
  ) u_prio (
    .hit_i   (hit_q),
    .found_o (found),
    .idx_o   (found_idx)
  );

  always_comb begin
    status_d = ST_OK;
    fpos_d   = '0;
    rdata_d  = '0;
    cmd      = '0;
    tidx     = '0;
    count_d  = count_q;
    case (req_q)
      REQ_INSERT: begin
        if (pos_ext > cnt_ext) begin
          status_d = ST_RANGE;
        end else if (cnt_ext >= CMP_W'(CAPACITY)) begin
          status_d = ST_FULL;
        end else begin
          cmd.shift_up = 1'b1;
          tidx         = pos_idx;
          count_d      = count_q + CNT_W'(1);
        end
      end
      REQ_APPEND: begin
        if (cnt_ext >= CMP_W'(CAPACITY)) begin
          status_d = ST_FULL;
        end else begin
          cmd.shift_up = 1'b1;
          tidx         = count_q[IDX_W-1:0];
          count_d      = count_q + CNT_W'(1);
        end
      end
      REQ_REMOVE_AT: begin
        if (pos_ext >= cnt_ext) begin
          status_d = ST_RANGE;
        end else begin
          cmd.shift_down = 1'b1;
          tidx           = pos_idx;
          count_d        = count_q - CNT_W'(1);
        end
      end
      REQ_READ: begin
        if (pos_ext >= cnt_ext) begin
          status_d = ST_RANGE;
        end else begin
          rdata_d = cell_data[pos_idx];
        end
      end
      REQ_FIND, REQ_REMOVE_VAL: begin
        if (found) begin
          fpos_d = found_idx;
          if (req_q == REQ_REMOVE_VAL) begin
            cmd.shift_down = 1'b1;
            tidx           = found_idx;
            count_d        = count_q - CNT_W'(1);
          end
        end else begin
          status_d = ST_MISSING;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        state_d = S_APPLY;
      end
      S_APPLY: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (apply_go) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_type_i;
      pos_q <= position_i;
      val_q <= item_value_i;
    end
    if (state_q == S_SRCH) begin
      hit_q <= hit_raw;
    end
    if (apply_go) begin
      status_q  <= status_d;
      fpos_q    <= FPOS_W'(fpos_d);
      rdata_q   <= VAL_W'(rdata_d);
      cnt_out_q <= COUNT_W'(count_d);
    end
  end

  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign found_position_o = fpos_q;
  assign read_data_o      = rdata_q;
  assign entry_count_o    = cnt_out_q;

  `OAL_ASSERT(a_count_bound, count_q <= CNT_W'(CAPACITY), "count above capacity")
  `OAL_ASSERT(a_count_hold, !apply_go |=> $stable(count_q), "count moved outside apply")
  `OAL_ASSERT(a_result_after_apply, apply_go |=> out_valid_q, "apply gave no result")
  `OAL_ASSERT(a_full_only_at_cap, out_valid_q && status_q == ST_FULL |-> count_q == CNT_W'(CAPACITY), "full reported below capacity")
  `OAL_ASSERT(a_remove_dec, apply_go && cmd.shift_down |=> count_q == $past(count_q) - CNT_W'(1), "remove did not drop count")

endmodule

// File: rtl/oal_cell.sv
// One storage cell of the list: holds an entry, compares it to the key and
// shifts with its neighbors. Depends on oal_pkg.
`timescale 1ns / 1ps
module oal_cell import oal_pkg::*; #(
  parameter int unsigned ENTRY_WIDTH = ENTRY_WIDTH_DEF,
  parameter int unsigned IDX_W       = $clog2(CAPACITY_DEF),
  parameter int unsigned CELL_IDX    = 0
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  oal_cmd_t               cmd_i,
  input  logic [IDX_W-1:0]       idx_i,
  input  logic [ENTRY_WIDTH-1:0] value_i,
  input  logic [ENTRY_WIDTH-1:0] prev_i,
  input  logic [ENTRY_WIDTH-1:0] next_i,
  output logic [ENTRY_WIDTH-1:0] data_o,
  output logic                   hit_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

  logic [ENTRY_WIDTH-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (cmd_i.shift_up) begin
      if (MyIdx > idx_i) begin
        data_d = prev_i;
      end else if (MyIdx == idx_i) begin
        data_d = value_i;
      end
    end
    if (cmd_i.shift_down && (MyIdx >= idx_i)) begin
      data_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;
  assign hit_o  = (data_q == value_i);

endmodule

// File: rtl/oal_prio.sv
// First-hit picker: index of the lowest set bit of the match vector.
// Depends on oal_pkg.
`timescale 1ns / 1ps
module oal_prio import oal_pkg::*; #(
  parameter int unsigned N     = CAPACITY_DEF,
  parameter int unsigned IDX_W = $clog2(CAPACITY_DEF)
) (
  input  logic [N-1:0]     hit_i,
  output logic             found_o,
  output logic [IDX_W-1:0] idx_o
);

  logic [N-1:0] first;

  assign first   = hit_i & (~hit_i + N'(1));
  assign found_o = |hit_i;

  always_comb begin
    idx_o = '0;
    for (int k = 0; k < N; k++) begin
      if (first[k]) begin
        idx_o = idx_o | IDX_W'(k);
      end
    end
  end

endmodule

// File: bench/testbench.sv
// Testbench for ordered_array_list: directed rows, then random request sequences.
// Results are checked against a list predictor kept in this file, or against the result typed in a directed row.
// Depends on oal_pkg and the ordered_array_list RTL.
`timescale 1ns / 1ps
module testbench;
  import oal_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNUSED_7 = 3'd7;
  localparam int ITEMS_TOTAL = 1050;
  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL_N = 6;
  localparam int SEQ_FILL = 0;
  localparam int SEQ_DRAIN = 1;
  localparam int SEQ_MIX = 2;
  localparam int MEM_IDX_W = $clog2(CAPACITY_DEF);

  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic [FPOS_W-1:0]  found_pos;
    logic [VAL_W-1:0]   read_data;
    logic [COUNT_W-1:0] entry_count;
  } list_result_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    logic             typed;
    list_result_t     res;
  } stim_row_t;

  localparam int N_ROWS = 22;
  localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
    '{REQ_READ,       5'd0,  32'h0,        1'b1, '{ST_RANGE,   4'd0, 32'h0,        5'd0}},
    '{REQ_REMOVE_AT,  5'd0,  32'h0,        1'b1, '{ST_RANGE,   4'd0, 32'h0,        5'd0}},
    '{REQ_FIND,       5'd0,  32'h0,        1'b1, '{ST_MISSING, 4'd0, 32'h0,        5'd0}},
    '{REQ_REMOVE_VAL, 5'd31, 32'hFFFFFFFF, 1'b1, '{ST_MISSING, 4'd0, 32'h0,        5'd0}},
    '{REQ_INSERT,     5'd1,  32'h1,        1'b1, '{ST_RANGE,   4'd0, 32'h0,        5'd0}},
    '{REQ_INSERT,     5'd0,  32'hFFFFFFFF, 1'b1, '{ST_OK,      4'd0, 32'h0,        5'd1}},
    '{REQ_APPEND,     5'd31, 32'h0,        1'b1, '{ST_OK,      4'd0, 32'h0,        5'd2}},
    '{REQ_INSERT,     5'd2,  32'hA5A5A5A5, 1'b1, '{ST_OK,      4'd0, 32'h0,        5'd3}},
    '{REQ_READ,       5'd0,  32'h0,        1'b1, '{ST_OK,      4'd0, 32'hFFFFFFFF, 5'd3}},
    '{REQ_READ,       5'd2,  32'hFFFFFFFF, 1'b0, '0},
    '{REQ_READ,       5'd31, 32'h0,        1'b1, '{ST_RANGE,   4'd0, 32'h0,        5'd3}},
    '{REQ_INSERT,     5'd31, 32'h5A5A5A5A, 1'b1, '{ST_RANGE,   4'd0, 32'h0,        5'd3}},
    '{REQ_FIND,       5'd0,  32'h0,        1'b1, '{ST_OK,      4'd1, 32'h0,        5'd3}},
    '{REQ_UNUSED_6,   5'd31, 32'hFFFFFFFF, 1'b1, '{ST_OK,      4'd0, 32'h0,        5'd3}},
    '{REQ_UNUSED_7,   5'd0,  32'h0,        1'b1, '{ST_OK,      4'd0, 32'h0,        5'd3}},
    '{REQ_INSERT,     5'd1,  32'h0,        1'b0, '0},
    '{REQ_FIND,       5'd0,  32'h0,        1'b0, '0},
    '{REQ_REMOVE_VAL, 5'd0,  32'h0,        1'b0, '0},
    '{REQ_REMOVE_AT,  5'd3,  32'h0,        1'b1, '{ST_RANGE,   4'd0, 32'h0,        5'd3}},
    '{REQ_REMOVE_VAL, 5'd0,  32'hFFFFFFFF, 1'b1, '{ST_OK,      4'd0, 32'h0,        5'd2}},
    '{REQ_REMOVE_AT,  5'd1,  32'h0,        1'b0, '0},
    '{REQ_READ,       5'd0,  32'h0,        1'b0, '0}
  };

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready_o;
  logic [REQ_W-1:0]   req_type = '0;
  logic [POS_W-1:0]   position = '0;
  logic [VAL_W-1:0]   item_value = '0;
  logic               out_valid_o;
  logic               out_ready = 1'b0;
  logic [ST_W-1:0]    status_o;
  logic [FPOS_W-1:0]  found_position_o;
  logic [VAL_W-1:0]   read_data_o;
  logic [COUNT_W-1:0] entry_count_o;

  // predictor state
  logic [VAL_W-1:0] list_mem [CAPACITY_DEF];
  int               list_len = 0;

  list_result_t     pending_results [$];
  logic [VAL_W-1:0] value_pool [POOL_N];
  int burst_left = 0;
  int n_sent = 0;
  int n_items = 0;
  int n_checked = 0;
  int n_errors = 0;
  int cycles = 0;
  int req_seen [8];
  int status_seen [4];

  ordered_array_list i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type),
    .position_i       (position),
    .item_value_i     (item_value),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .status_o         (status_o),
    .found_position_o (found_position_o),
    .read_data_o      (read_data_o),
    .entry_count_o    (entry_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic list_result_t list_apply(logic [REQ_W-1:0] req, logic [POS_W-1:0] pos,
                                              logic [VAL_W-1:0] val);
    list_result_t res;
    int hit;
    res = '0;
    hit = -1;
    case (req)
      REQ_INSERT: begin
        if (pos > list_len) begin
          res.status = ST_RANGE;
        end else if (list_len >= CAPACITY_DEF) begin
          res.status = ST_FULL;
        end else begin
          for (int i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[MEM_IDX_W'(pos)] = val;
          list_len++;
        end
      end
      REQ_APPEND: begin
        if (list_len >= CAPACITY_DEF) begin
          res.status = ST_FULL;
        end else begin
          list_mem[MEM_IDX_W'(list_len)] = val;
          list_len++;
        end
      end
      REQ_REMOVE_AT: begin
        if (pos >= list_len) begin
          res.status = ST_RANGE;
        end else begin
          for (int i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      REQ_READ: begin
        if (pos >= list_len) res.status = ST_RANGE;
        else res.read_data = list_mem[MEM_IDX_W'(pos)];
      end
      REQ_FIND, REQ_REMOVE_VAL: begin
        for (int i = 0; i < list_len; i++) begin
          if (hit < 0 && list_mem[i] == val) hit = i;
        end
        if (hit < 0) begin
          res.status = ST_MISSING;
        end else begin
          res.found_pos = hit[FPOS_W-1:0];
          if (req == REQ_REMOVE_VAL) begin
            for (int i = hit; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
            list_len--;
          end
        end
      end
      default: ;
    endcase
    res.entry_count = list_len[COUNT_W-1:0];
    return res;
  endfunction

  // offers one item, idling between bursts; returns at the accepting edge
  task automatic send_item(input logic [REQ_W-1:0] req, input logic [POS_W-1:0] pos,
                           input logic [VAL_W-1:0] val, input logic typed,
                           input list_result_t typed_res);
    list_result_t res;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    in_valid   <= 1'b1;
    req_type   <= req;
    position   <= pos;
    item_value <= val;
    do @(posedge clk_i); while (!in_ready_o);
    res = list_apply(req, pos, val);
    pending_results.push_back(typed ? typed_res : res);
    req_seen[req]++;
    n_sent++;
    if (req != REQ_UNUSED_6 && req != REQ_UNUSED_7) n_items++;
  endtask

  task automatic drain_pause();
    in_valid <= 1'b0;
    burst_left = 1;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [VAL_W-1:0] pick_value(bit from_list);
    if (from_list && list_len > 0 && $urandom_range(0, 9) < 6)
      return list_mem[$urandom_range(0, list_len - 1)];
    if ($urandom_range(0, 9) < 7) return value_pool[$urandom_range(0, POOL_N - 1)];
    return $urandom;
  endfunction

  function automatic logic [POS_W-1:0] pick_pos(bit inclusive);
    int hi;
    hi = inclusive ? list_len : list_len - 1;
    case ($urandom_range(0, 9))
      0: return POS_W'($urandom_range(0, 31));
      1: return list_len[POS_W-1:0];
      default: return (hi < 0) ? '0 : POS_W'($urandom_range(0, hi));
    endcase
  endfunction

  task automatic random_op(input int bias);
    int roll;
    logic [REQ_W-1:0] req;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      req = roll[0] ? REQ_UNUSED_7 : REQ_UNUSED_6;
    end else if (bias == SEQ_FILL) begin
      req = (roll < 45) ? REQ_INSERT : (roll < 75) ? REQ_APPEND : (roll < 85) ? REQ_READ :
            (roll < 95) ? REQ_FIND : REQ_REMOVE_AT;
    end else if (bias == SEQ_DRAIN) begin
      req = (roll < 40) ? REQ_REMOVE_AT : (roll < 70) ? REQ_REMOVE_VAL :
            (roll < 80) ? REQ_READ : (roll < 90) ? REQ_FIND : REQ_INSERT;
    end else begin
      req = (roll < 20) ? REQ_INSERT : (roll < 35) ? REQ_APPEND :
            (roll < 50) ? REQ_REMOVE_AT : (roll < 65) ? REQ_READ :
            (roll < 80) ? REQ_FIND : REQ_REMOVE_VAL;
    end
    send_item(req, pick_pos(req == REQ_INSERT),
              pick_value(req == REQ_FIND || req == REQ_REMOVE_VAL), 1'b0, '0);
  endtask

  // receiver: changing stall patterns plus two long hold-offs
  initial begin
    int stall_left;
    int hold_mark;
    int mode;
    int phase;
    stall_left = 0;
    hold_mark = 300;
    mode = 0;
    phase = 0;
    forever begin
      @(posedge clk_i);
      phase++;
      if (phase % 64 == 0) mode = $urandom_range(0, 3);
      if (stall_left == 0 && n_sent >= hold_mark && hold_mark < 1000) begin
        stall_left = 120;
        hold_mark += 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (phase % 3 == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    list_result_t want;
    list_result_t got;
    if (rst_ni && out_valid_o && out_ready) begin
      got = '{status_o, found_position_o, read_data_o, entry_count_o};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result st=%0d pos=%0d data=%h cnt=%0d", $realtime,
                 got.status, got.found_pos, got.read_data, got.entry_count);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        status_seen[want.status]++;
        if (got !== want) begin
          $display({"%0t: result %0d mismatch: expected st=%0d pos=%0d data=%h cnt=%0d,",
                    " actual st=%0d pos=%0d data=%h cnt=%0d"},
                   $realtime, n_checked, want.status, want.found_pos, want.read_data,
                   want.entry_count, got.status, got.found_pos, got.read_data,
                   got.entry_count);
          n_errors++;
        end
      end
      n_checked++;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $realtime, pending_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    bit first_seq;
    int kind;
    first_seq = 1'b1;
    foreach (req_seen[i]) req_seen[i] = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    value_pool[0] = '0;
    value_pool[1] = '1;
    for (int i = 2; i < POOL_N; i++) value_pool[i] = $urandom;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_ROWS; i++)
      send_item(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].pos, DIRECTED_ROWS[i].val,
                DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
    drain_pause();

    while (n_items < ITEMS_TOTAL) begin
      kind = first_seq ? SEQ_FILL : $urandom_range(SEQ_FILL, SEQ_MIX);
      first_seq = 1'b0;
      case (kind)
        SEQ_FILL: begin
          while (list_len < CAPACITY_DEF) random_op(SEQ_FILL);
          repeat ($urandom_range(2, 5)) random_op(SEQ_FILL);
        end
        SEQ_DRAIN: begin
          while (list_len > 0) random_op(SEQ_DRAIN);
          repeat ($urandom_range(2, 5)) random_op(SEQ_DRAIN);
        end
        default: repeat ($urandom_range(10, 40)) random_op(SEQ_MIX);
      endcase
      if ($urandom_range(0, 9) == 0) drain_pause();
    end

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display({"%0d requests (%0d insert, %0d append, %0d remove-at, %0d read, %0d find,",
              " %0d remove-value, %0d unused codes)"},
             n_sent, req_seen[REQ_INSERT], req_seen[REQ_APPEND], req_seen[REQ_REMOVE_AT],
             req_seen[REQ_READ], req_seen[REQ_FIND], req_seen[REQ_REMOVE_VAL],
             req_seen[REQ_UNUSED_6] + req_seen[REQ_UNUSED_7]);
    $display("%0d results checked: %0d ok, %0d out of range, %0d full, %0d not found",
             n_checked, status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_FULL],
             status_seen[ST_MISSING]);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: ordered_array_list.f
+incdir+rtl
rtl/oal_pkg.sv
rtl/oal_cell.sv
rtl/oal_prio.sv
rtl/ordered_array_list.sv
bench/testbench.sv
